>>> hdl/quarter_wave_sine_interp_macros.svh
// Assertion macros for the quarter-wave sine interpolator.
// Used by the top-level RTL file under hdl; define ASSERT_OFF to compile them out.
`ifndef QUARTER_WAVE_SINE_INTERP_MACROS_SVH
`define QUARTER_WAVE_SINE_INTERP_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clk edge outside reset.
`define QWSI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check a property on every rising clk edge, reset included.
`define QWSI_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define QWSI_ASSERT(lbl, prop, msg)
`define QWSI_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> hdl/qwsi_pkg.sv
// Shared types, widths and the first-quadrant sine table for the interpolator.
// No dependencies; imported by every module of the block.
`default_nettype none

package qwsi_pkg;

	localparam int AngleW = 14;
	localparam int SineW  = 16;
	localparam int MagW   = 15;
	localparam int FracW  = 8;
	localparam int IdxW   = 4;
	localparam int TabIdxW = 5;

	// Values of stage 1, handed from the table lookup to the interpolation.
	typedef struct packed {
		logic [MagW-1:0]  base;    // anchor entry: lower one, or upper one when mirrored
		logic [MagW-1:0]  diff;    // upper entry minus lower entry
		logic [FracW-1:0] frac;
		logic             mirror;  // quadrants 2 and 4
		logic             negate;  // quadrants 3 and 4
	} lookup_t;

	// sin(k * 90deg / 16) * 32767, k = 0..16
	function automatic logic [MagW-1:0] quarter_sine(input logic [TabIdxW-1:0] k);
		logic [MagW-1:0] v;
		unique case (k)
			5'd0:    v = 15'd0;
			5'd1:    v = 15'd3211;
			5'd2:    v = 15'd6392;
			5'd3:    v = 15'd9511;
			5'd4:    v = 15'd12539;
			5'd5:    v = 15'd15446;
			5'd6:    v = 15'd18204;
			5'd7:    v = 15'd20787;
			5'd8:    v = 15'd23169;
			5'd9:    v = 15'd25329;
			5'd10:   v = 15'd27244;
			5'd11:   v = 15'd28897;
			5'd12:   v = 15'd30272;
			5'd13:   v = 15'd31356;
			5'd14:   v = 15'd32137;
			5'd15:   v = 15'd32609;
			5'd16:   v = 15'd32767;
			default: v = 15'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> hdl/qwsi_lookup.sv
// Table lookup: splits the angle, mirrors the index and reads both neighbor entries.
// Depends on qwsi_pkg.
`default_nettype none

module qwsi_lookup (
	input  wire logic [qwsi_pkg::AngleW-1:0] angle,
	output qwsi_pkg::lookup_t                lk
);
	import qwsi_pkg::*;

	logic [IdxW-1:0]    idx;
	logic [TabIdxW-1:0] lo_k;
	logic [MagW-1:0]    lo;
	logic [MagW-1:0]    hi;

	always_comb begin
		// mirror the index in quadrants 2 and 4, where the magnitude falls
		idx  = angle[12] ? ~angle[11:8] : angle[11:8];
		lo_k = {1'b0, idx};
		lo   = quarter_sine(lo_k);
		hi   = quarter_sine(lo_k + 5'd1);
		lk.base   = angle[12] ? hi : lo;
		lk.diff   = hi - lo;
		lk.frac   = angle[FracW-1:0];
		lk.mirror = angle[12];
		lk.negate = angle[13];
	end

endmodule

`default_nettype wire

>>> hdl/qwsi_interp.sv
// Interpolation: scales the entry difference by the fraction and applies mirror and sign.
// Depends on qwsi_pkg.
`default_nettype none

module qwsi_interp (
	input  wire qwsi_pkg::lookup_t        lk,
	output logic [qwsi_pkg::SineW-1:0]    sine
);
	import qwsi_pkg::*;

	logic [MagW+FracW-1:0] prod;
	logic [MagW-1:0]       delta;
	logic [MagW-1:0]       mag;

	always_comb begin
		prod  = {{FracW{1'b0}}, lk.diff} * {{MagW{1'b0}}, lk.frac};
		delta = prod[MagW+FracW-1:FracW];
		mag   = lk.mirror ? (lk.base - delta) : (lk.base + delta);
		sine  = lk.negate ? (SineW'(0) - {1'b0, mag}) : {1'b0, mag};
	end

endmodule

`default_nettype wire

>>> hdl/quarter_wave_sine_interp.sv
// Top level of the quarter-wave sine interpolator: stream ports and stage registers.
// Depends on qwsi_pkg, qwsi_lookup, qwsi_interp and the assertion macro header.
//
// Maps a 14-bit phase (two quadrant bits, four table-index bits, eight fraction
// bits) to a signed 16-bit sine scaled by 32767, interpolating linearly in a
// 17-entry first-quadrant table. One transaction per clock is sustained; each
// input is held in the stage 1 register as its lookup values, and its result in
// the output register: the table is read ahead of the first register, and the
// one 15x8 multiply and the add/negate run between them. A stall on the output
// holds both stages; an empty stage still takes new input.
`default_nettype none
`include "quarter_wave_sine_interp_macros.svh"

module quarter_wave_sine_interp (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [13:0] angle, [15:14] zero
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata    // [15:0] sine
);
	import qwsi_pkg::*;

	lookup_t          lk;
	lookup_t          lk_s1;
	logic             v_s1;
	logic [SineW-1:0] sine;
	logic [SineW-1:0] sine_s2;
	logic             adv_s2;
	logic             adv_s1;

	qwsi_lookup u_lookup (
		.angle (s_axis_tdata[AngleW-1:0]),
		.lk    (lk)
	);

	qwsi_interp u_interp (
		.lk   (lk_s1),
		.sine (sine)
	);

	assign adv_s2        = !m_axis_tvalid || m_axis_tready;
	assign adv_s1        = !v_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				m_axis_tvalid <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			lk_s1 <= lk;
		end
		if (adv_s2 && v_s1) begin
			sine_s2 <= sine;
		end
	end

	assign m_axis_tdata = sine_s2;

	`QWSI_ASSERT(a_empty_takes, !v_s1 |-> s_axis_tready, "empty stage 1 refused input")
	`QWSI_ASSERT(a_moves_on, (v_s1 && adv_s2) |=> m_axis_tvalid, "stage 1 item was lost")
	`QWSI_ASSERT(a_range, m_axis_tvalid |-> (m_axis_tdata != 16'h8000), "sine out of range")
	`QWSI_ASSERT(a_no_gap, (m_axis_tvalid && !m_axis_tready && v_s1) |=> v_s1,
		"stalled stage 1 item dropped")
	`QWSI_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !m_axis_tvalid, "output valid in reset")

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Testbench for quarter_wave_sine_interp: stream angles in, check every sine against a predictor.
// Depends on qwsi_pkg and the RTL under hdl; needs no files or arguments at run time.
`timescale 1ns / 100ps

module testbench;
	import qwsi_pkg::AngleW;
	import qwsi_pkg::SineW;

	localparam int WatchdogLimit = 2000;
	localparam int TailCycles    = 8;

	// sin(k * 90deg / 16) * 32767, k = 0..16
	localparam int unsigned QuarterSine[17] = '{
		0, 3211, 6392, 9511, 12539, 15446, 18204, 20787,
		23169, 25329, 27244, 28897, 30272, 31356, 32137, 32609,
		32767
	};

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b1;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;   // [13:0] angle, [15:14] zero
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;         // [15:0] sine

	logic [SineW-1:0] expected_sines[$];
	int               mismatch_count = 0;
	int               tx_idle_pct    = 0;
	int               rx_idle_pct    = 0;
	int               quiet_cycles   = 0;

	quarter_wave_sine_interp i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #2 clk = ~clk;

	function automatic logic [SineW-1:0] predict_sine(input logic [AngleW-1:0] angle);
		int unsigned frac;
		int unsigned seg;
		int unsigned lower;
		int unsigned upper;
		int unsigned delta;
		int unsigned mag;
		frac = angle[7:0];
		seg  = angle[11:8];
		// mirror the table walk in quadrants 2 and 4
		if (angle[12]) begin
			seg = 15 - seg;
		end
		lower = QuarterSine[seg];
		upper = QuarterSine[seg + 1];
		delta = ((upper - lower) * frac) >> 8;
		mag   = angle[12] ? (upper - delta) : (lower + delta);
		return angle[13] ? SineW'(-mag) : SineW'(mag);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Hold tvalid across back-to-back transactions; drop it only for a gap.
	task automatic send_angle(input logic [AngleW-1:0] angle);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, angle};
		do @(posedge clk); while (!s_axis_tready);
		expected_sines.push_back(predict_sine(angle));
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_sines.size() != 0) @(posedge clk);
	endtask

	// Receiver: stall at random with the current idle rate.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		logic [SineW-1:0] want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_sines.size() == 0) begin
				report_mismatch("unexpected sine", $signed(m_axis_tdata), 0);
			end else begin
				want = expected_sines.pop_front();
				if (m_axis_tdata !== want) begin
					report_mismatch("sine", $signed(m_axis_tdata), $signed(want));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= WatchdogLimit) begin
				$display("[%0t] watchdog: no transaction for %0d cycles", $realtime, WatchdogLimit);
				$display("end of test: mismatches");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Quadrant edges, table ends, fraction extremes and bit patterns.
	task automatic test_corner_angles();
		logic [AngleW-1:0] corners[$];
		corners = '{
			14'h0000, 14'h3FFF, 14'h0FFF, 14'h1000, 14'h1FFF, 14'h2000,
			14'h2FFF, 14'h3000, 14'h00FF, 14'h10FF, 14'h20FF, 14'h30FF,
			14'h0F80, 14'h1F80, 14'h2F80, 14'h3F80, 14'h0800, 14'h1800,
			14'h2800, 14'h3800, 14'h2AAA, 14'h1555, 14'h0001, 14'h3F01
		};
		foreach (corners[i]) begin
			send_angle(corners[i]);
		end
	endtask

	// Mostly oscillator-style phase ramps with random step, the rest uniform angles.
	task automatic test_random_angles(input int count);
		logic [AngleW-1:0] phase;
		logic [AngleW-1:0] step;
		int                run;
		phase = AngleW'($urandom);
		step  = AngleW'($urandom_range(1, 600));
		run   = 0;
		for (int n = 0; n < count; n++) begin
			if (run == 0 && $urandom_range(99) < 30) begin
				send_angle(AngleW'($urandom));
			end else begin
				if (run == 0) begin
					run   = $urandom_range(8, 64);
					phase = AngleW'($urandom);
					step  = ($urandom_range(3) == 0) ? AngleW'($urandom)
					                                 : AngleW'($urandom_range(1, 600));
				end
				send_angle(phase);
				phase += step;
				run--;
			end
		end
	endtask

	// Let the pipeline run dry, then push a burst into the empty stages.
	task automatic test_burst_after_drain();
		drain_results();
		tx_idle_pct = 0;
		for (int n = 0; n < 20; n++) begin
			send_angle(AngleW'($urandom));
		end
	endtask

	initial begin
		// assert reset with a falling edge so the asynchronous reset takes effect at once
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 9;
		rx_idle_pct = 70;
		test_corner_angles();
		test_random_angles(600);

		tx_idle_pct = 70;
		rx_idle_pct = 9;
		test_random_angles(600);

		test_burst_after_drain();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_angles(580);

		drain_results();
		repeat (TailCycles) @(posedge clk);
		if (expected_sines.size() != 0) begin
			report_mismatch("sines never delivered", 0, expected_sines.size());
		end
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
